[sv/krg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package krg_pkg;

	localparam int unsigned WORD_W = 32;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		OP_SEED   = 2'd0,
		OP_RAW    = 2'd1,
		OP_RANGED = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_SEEDED    = 2'd1,
		ST_BAD_RANGE = 2'd2
	} status_t;

	localparam word_t LCG_MULT = 32'd69069;
	localparam word_t LCG_INC  = 32'd1;
	localparam int unsigned XS_A = 13;
	localparam int unsigned XS_B = 17;
	localparam int unsigned XS_C = 5;
	localparam int unsigned CARRY_SHIFT = 30;
	localparam int unsigned CARRY_W = 2;
	localparam word_t SIGN_FLIP = 32'h8000_0000;

	typedef struct packed {
		logic  load;
		logic  advance;
		word_t seed;
	} gen_cmd_t;

	typedef struct packed {
		logic  start;
		word_t dividend;
		word_t divisor;
	} div_cmd_t;

endpackage

`default_nettype wire

[sv/krg_gen.sv]
`timescale 1ns / 1ps
`default_nettype none

module krg_gen (
	input  wire               clk,
	input  wire               arst_n,
	input  krg_pkg::gen_cmd_t cmd,
	output krg_pkg::word_t    raw,
	output logic              seeded
);

	krg_pkg::word_t lcg_q, xs_q, lag_old_q, lag_new_q;
	logic [krg_pkg::CARRY_W-1:0] carry_q;
	logic seeded_q;

	krg_pkg::word_t seed_eff, lcg_next, xs_a, xs_b, xs_next, tmp, lag_next, carry_ext;

	always_comb begin
		seed_eff  = (cmd.seed == '0) ? krg_pkg::word_t'(1) : cmd.seed;
		carry_ext = {{(krg_pkg::WORD_W-krg_pkg::CARRY_W){1'b0}}, carry_q};
		lcg_next  = lcg_q * krg_pkg::LCG_MULT + krg_pkg::LCG_INC;
		xs_a      = xs_q ^ (xs_q << krg_pkg::XS_A);
		xs_b      = xs_a ^ (xs_a >> krg_pkg::XS_B);
		xs_next   = xs_b ^ (xs_b << krg_pkg::XS_C);
		tmp       = (lag_old_q >> 2) + (lag_new_q >> 3) + (carry_ext >> 2);
		lag_next  = (lag_new_q << 1) + lag_old_q + carry_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q     <= '0;
			xs_q      <= '0;
			lag_old_q <= '0;
			lag_new_q <= '0;
			carry_q   <= '0;
			seeded_q  <= 1'b0;
		end else if (cmd.load) begin
			lcg_q     <= seed_eff | 32'd1;
			xs_q      <= seed_eff | 32'd2;
			lag_old_q <= seed_eff | 32'd4;
			lag_new_q <= seed_eff | 32'd8;
			carry_q   <= '0;
			seeded_q  <= 1'b1;
		end else if (cmd.advance) begin
			lcg_q     <= lcg_next;
			xs_q      <= xs_next;
			lag_old_q <= lag_new_q;
			lag_new_q <= lag_next;
			carry_q   <= tmp[krg_pkg::WORD_W-1:krg_pkg::CARRY_SHIFT];
		end
	end

	assign raw    = lcg_q + xs_q + lag_new_q;
	assign seeded = seeded_q;

endmodule

`default_nettype wire

[sv/krg_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module krg_div (
	input  wire               clk,
	input  wire               arst_n,
	input  krg_pkg::div_cmd_t cmd,
	output logic              done,
	output krg_pkg::word_t    remainder
);

	localparam int unsigned CNT_W = $clog2(krg_pkg::WORD_W + 1);

	logic                 busy_q, done_q;
	logic [CNT_W-1:0]     cnt_q;
	krg_pkg::word_t       dvd_q, dvs_q, rem_q;
	logic [krg_pkg::WORD_W:0] shifted, diff;

	always_comb begin
		shifted = {rem_q, dvd_q[krg_pkg::WORD_W-1]};
		diff    = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(krg_pkg::WORD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvd_q <= cmd.dividend;
			dvs_q <= cmd.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= diff[krg_pkg::WORD_W] ? shifted[krg_pkg::WORD_W-1:0]
			                               : diff[krg_pkg::WORD_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

[sv/kiss_random_generator.sv]
// KISS-style 32-bit random generator: a 69069 congruential word, a 13/17/5
// xorshift word and a carry-add lag pair, summed modulo 2^32. Operation 0
// seeds the state (only the first seed after reset is honored, a zero seed
// counts as 1), 1 draws a raw word and its Q1.31 fraction, 2 also returns
// range_min + raw mod (range_max - range_min + 1), or status 2 for a bad
// range. One transaction is in flight at a time and in_stall stays high
// until its result is taken. Seed, ignored and rejected operations can hand
// their result over in the cycle after accept; a raw draw passes the advance
// and sum states first, a ranged draw also the divide state, in which the
// restoring divider retires one remainder bit per cycle. After a result is
// taken the block goes back to idle before it takes the next transaction.
`timescale 1ns / 1ps
`default_nettype none

module kiss_random_generator (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  operation,
	input  wire  [31:0] seed,
	input  wire  signed [31:0] range_min,
	input  wire  signed [31:0] range_max,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  status,
	output logic [31:0] raw_value,
	output logic signed [31:0] signed_fraction,
	output logic signed [31:0] ranged_value
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADV,
		S_SUM,
		S_DIV,
		S_OUT
	} state_t;

	state_t            state_q;
	logic              ranged_q;
	krg_pkg::status_t  status_q;
	krg_pkg::word_t    raw_q, ranged_val_q, min_q, span_q;
	krg_pkg::word_t    frac_q;
	logic              drew_q;

	krg_pkg::gen_cmd_t gen_cmd;
	krg_pkg::div_cmd_t div_cmd;
	krg_pkg::word_t    gen_raw, rem;
	logic              seeded, div_done, accept, bad_range;
	krg_pkg::word_t    span;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign span      = krg_pkg::word_t'(range_max - range_min + 32'sd1);
	assign bad_range = (range_max <= range_min) || (span == '0);

	always_comb begin
		gen_cmd.load     = accept && (operation == krg_pkg::OP_SEED) && !seeded;
		gen_cmd.advance  = (state_q == S_ADV);
		gen_cmd.seed     = seed;
		div_cmd.start    = (state_q == S_SUM) && ranged_q;
		div_cmd.dividend = gen_raw;
		div_cmd.divisor  = span_q;
	end

	krg_gen u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (gen_cmd),
		.raw    (gen_raw),
		.seeded (seeded)
	);

	krg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (div_cmd),
		.done      (div_done),
		.remainder (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ranged_q     <= 1'b0;
			status_q     <= krg_pkg::ST_OK;
			raw_q        <= '0;
			ranged_val_q <= '0;
			min_q        <= '0;
			span_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						raw_q        <= '0;
						ranged_val_q <= '0;
						status_q     <= krg_pkg::ST_OK;
						ranged_q     <= 1'b0;
						min_q        <= krg_pkg::word_t'(range_min);
						span_q       <= span;
						state_q      <= S_OUT;
						case (operation)
							krg_pkg::OP_SEED: begin
								if (seeded)
									status_q <= krg_pkg::ST_SEEDED;
							end
							krg_pkg::OP_RAW: begin
								state_q <= S_ADV;
							end
							krg_pkg::OP_RANGED: begin
								if (bad_range) begin
									status_q <= krg_pkg::ST_BAD_RANGE;
								end else begin
									ranged_q <= 1'b1;
									state_q  <= S_ADV;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_ADV: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					raw_q   <= gen_raw;
					state_q <= ranged_q ? S_DIV : S_OUT;
				end
				S_DIV: begin
					if (div_done) begin
						ranged_val_q <= min_q + rem;
						state_q      <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_stall)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall        = (state_q != S_IDLE);
	assign out_valid       = (state_q == S_OUT);
	assign status          = status_q;
	assign raw_value       = raw_q;
	assign signed_fraction = $signed(frac_q);
	assign ranged_value    = $signed(ranged_val_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drew_q <= 1'b0;
		end else if (accept) begin
			drew_q <= 1'b0;
		end else if (state_q == S_SUM) begin
			drew_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			frac_q <= '0;
		else if (state_q == S_SUM)
			frac_q <= gen_raw ^ krg_pkg::SIGN_FLIP;
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_bad_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status_q == krg_pkg::ST_BAD_RANGE) |->
			(raw_q == '0 && ranged_val_q == '0 && !drew_q))
		else $error("rejected range produced a draw");

	a_ranged_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ranged_q) |-> ((ranged_val_q - min_q) < span_q))
		else $error("ranged value outside span");

	a_frac_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && drew_q) |-> (frac_q == (raw_q ^ krg_pkg::SIGN_FLIP)))
		else $error("fraction does not track raw word");

endmodule

`default_nettype wire

[test/kiss_random_generator_checker.sv]
`timescale 1ns / 1ps

module kiss_random_generator_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire  [1:0]  operation,
	input  wire  [31:0] seed,
	input  wire  [31:0] range_min,
	input  wire  [31:0] range_max,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire  [1:0]  status,
	input  wire  [31:0] raw_value,
	input  wire  [31:0] signed_fraction,
	input  wire  [31:0] ranged_value,
	output int          fail_count,
	output int          outstanding
);

	localparam krg_pkg::word_t CONG_MUL = 32'd69069;
	localparam krg_pkg::word_t TOP_BIT  = 32'h8000_0000;

	typedef struct packed {
		krg_pkg::status_t status;
		krg_pkg::word_t   raw;
		krg_pkg::word_t   frac;
		krg_pkg::word_t   ranged;
	} draw_t;

	krg_pkg::word_t cong_w;
	krg_pkg::word_t shift_w;
	krg_pkg::word_t lag_a;
	krg_pkg::word_t lag_b;
	krg_pkg::word_t carry_w;
	logic  seeded;

	draw_t draw_q[$];
	draw_t got;
	draw_t want;
	int    err_cnt;

	function automatic krg_pkg::word_t kiss_advance();
		krg_pkg::word_t y;
		krg_pkg::word_t t;
		krg_pkg::word_t n;
		cong_w = cong_w * CONG_MUL + 32'd1;
		y = shift_w;
		y = y ^ (y << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		shift_w = y;
		t = (lag_a >> 2) + (lag_b >> 3) + (carry_w >> 2);
		n = lag_b + lag_b + lag_a + carry_w;
		lag_a = lag_b;
		lag_b = n;
		carry_w = t >> 30;
		return cong_w + shift_w + lag_b;
	endfunction

	function automatic draw_t predict_draw(input krg_pkg::op_t op, input krg_pkg::word_t sd,
			input krg_pkg::word_t lo, input krg_pkg::word_t hi);
		draw_t r;
		krg_pkg::word_t span;
		r = '0;
		r.status = krg_pkg::ST_OK;
		span = hi - lo + 32'd1;
		case (op)
			krg_pkg::OP_SEED: begin
				if (seeded) begin
					r.status = krg_pkg::ST_SEEDED;
				end else begin
					if (sd == '0)
						sd = 32'd1;
					cong_w = sd | 32'd1;
					shift_w = sd | 32'd2;
					lag_a = sd | 32'd4;
					lag_b = sd | 32'd8;
					carry_w = '0;
					seeded = 1'b1;
				end
			end
			krg_pkg::OP_RAW: begin
				r.raw = kiss_advance();
				r.frac = r.raw ^ TOP_BIT;
			end
			krg_pkg::OP_RANGED: begin
				if ($signed(hi) <= $signed(lo) || span == '0) begin
					r.status = krg_pkg::ST_BAD_RANGE;
				end else begin
					r.raw = kiss_advance();
					r.frac = r.raw ^ TOP_BIT;
					r.ranged = lo + r.raw % span;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cong_w = '0;
			shift_w = '0;
			lag_a = '0;
			lag_b = '0;
			carry_w = '0;
			seeded = 1'b0;
			draw_q.delete();
			err_cnt = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.status = krg_pkg::status_t'(status);
				got.raw = raw_value;
				got.frac = signed_fraction;
				got.ranged = ranged_value;
				if (draw_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected result: status %0d raw %h frac %h ranged %h",
							status, raw_value, signed_fraction, ranged_value);
				end else begin
					want = draw_q.pop_front();
					if (got !== want) begin
						err_cnt++;
						if (err_cnt <= 10) begin
							$display("mismatch: expected status %0d raw %h frac %h ranged %h",
								want.status, want.raw, want.frac, want.ranged);
							$display("          got status %0d raw %h frac %h ranged %h",
								status, raw_value, signed_fraction, ranged_value);
						end
					end
				end
			end
			if (in_valid && !in_stall)
				draw_q.push_back(predict_draw(krg_pkg::op_t'(operation), seed, range_min,
					range_max));
			outstanding <= draw_q.size();
			fail_count <= err_cnt;
		end
	end

endmodule

[test/kiss_random_generator_tb.sv]
`timescale 1ns / 1ps

module kiss_random_generator_tb;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic        [1:0]  operation = krg_pkg::OP_NONE;
	logic        [31:0] seed = '0;
	logic signed [31:0] range_min = '0;
	logic signed [31:0] range_max = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic        [1:0]  status;
	logic        [31:0] raw_value;
	logic signed [31:0] signed_fraction;
	logic signed [31:0] ranged_value;

	int          fail_count;
	int          outstanding;
	int unsigned cycle_cnt = 0;
	int          stall_left = 0;
	logic        tx_quiet = 1'b0;
	logic        rx_quiet = 1'b0;

	kiss_random_generator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.seed(seed),
		.range_min(range_min),
		.range_max(range_max),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.raw_value(raw_value),
		.signed_fraction(signed_fraction),
		.ranged_value(ranged_value)
	);

	kiss_random_generator_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.seed(seed),
		.range_min(range_min),
		.range_max(range_max),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.raw_value(raw_value),
		.signed_fraction(signed_fraction),
		.ranged_value(ranged_value),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("kiss_random_generator verification failed");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			if (!rx_quiet && $urandom_range(0, 99) < 30)
				stall_left <= gap_len();
		end
	end

	task automatic send_item(input krg_pkg::op_t op, input krg_pkg::word_t sd,
			input krg_pkg::word_t lo, input krg_pkg::word_t hi);
		int n;
		in_valid <= 1'b1;
		operation <= op;
		seed <= sd;
		range_min <= lo;
		range_max <= hi;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n = (tx_quiet || $urandom_range(0, 99) < 55) ? 0 : gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// hold off until every transaction in flight has returned
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic pick_range(output krg_pkg::word_t lo, output krg_pkg::word_t hi);
		krg_pkg::word_t t;
		lo = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				hi = lo + $urandom_range(1, 1000);
			end
			4, 5, 6: begin
				hi = $urandom;
				if ($signed(hi) < $signed(lo)) begin
					t = lo;
					lo = hi;
					hi = t;
				end
			end
			7: begin
				hi = $urandom;
			end
			8: begin
				hi = lo - $urandom_range(0, 3);
			end
			default: begin
				lo = 32'h8000_0000 + $urandom_range(0, 2);
				hi = 32'h7fff_ffff - $urandom_range(0, 2);
			end
		endcase
	endtask

	task automatic random_item();
		int r;
		krg_pkg::word_t sd;
		krg_pkg::word_t lo;
		krg_pkg::word_t hi;
		r = $urandom_range(0, 99);
		sd = $urandom;
		lo = $urandom;
		hi = $urandom;
		if (r < 45) begin
			send_item(krg_pkg::OP_RAW, sd, lo, hi);
		end else if (r < 85) begin
			pick_range(lo, hi);
			send_item(krg_pkg::OP_RANGED, sd, lo, hi);
		end else if (r < 95) begin
			send_item(krg_pkg::OP_SEED, sd, lo, hi);
		end else begin
			send_item(krg_pkg::OP_NONE, sd, lo, hi);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// draws on the cleared state, before any seed
		send_item(krg_pkg::OP_RAW, '0, '0, '0);
		send_item(krg_pkg::OP_RANGED, '1, 32'd0, 32'd9);
		send_item(krg_pkg::OP_NONE, '1, '1, '1);
		send_item(krg_pkg::OP_SEED, 32'd0, $urandom, $urandom);
		send_item(krg_pkg::OP_SEED, 32'hffff_ffff, '1, '0);
		send_item(krg_pkg::OP_RAW, $urandom, $urandom, $urandom);
		send_item(krg_pkg::OP_RAW, $urandom, $urandom, $urandom);
		send_item(krg_pkg::OP_RANGED, '0, 32'd5, 32'd5);
		send_item(krg_pkg::OP_RANGED, '0, 32'd10, -32'sd10);
		send_item(krg_pkg::OP_RANGED, '0, 32'h8000_0000, 32'h7fff_ffff);
		send_item(krg_pkg::OP_RANGED, '0, 32'h7fff_ffff, 32'h8000_0000);
		send_item(krg_pkg::OP_RANGED, '0, 32'h8000_0000, 32'h7fff_fffe);
		send_item(krg_pkg::OP_RANGED, '0, 32'h7fff_fffe, 32'h7fff_ffff);
		send_item(krg_pkg::OP_RANGED, '0, 32'h8000_0000, 32'h8000_0001);
		send_item(krg_pkg::OP_RANGED, '0, 32'hffff_ffff, 32'd0);
		send_item(krg_pkg::OP_RANGED, '0, 32'd0, 32'd1);
		send_item(krg_pkg::OP_RANGED, '0, 32'h0000_0001, 32'h7fff_ffff);
		send_item(krg_pkg::OP_NONE, '0, '0, '0);
		send_item(krg_pkg::OP_SEED, '0, '0, '0);
		send_item(krg_pkg::OP_RAW, '1, '1, '1);
		drain();

		for (int p = 0; p < 4; p++) begin
			tx_quiet <= (p == 1) || (p == 3);
			rx_quiet <= (p == 2) || (p == 3);
			repeat (500) random_item();
			drain();
		end

		repeat (60) @(posedge clk);
		if (fail_count == 0) begin
			$display("kiss_random_generator verification clean");
		end else begin
			$display("kiss_random_generator verification failed");
		end
		$finish;
	end

endmodule

[files.f]
sv/krg_pkg.sv
sv/krg_gen.sv
sv/krg_div.sv
sv/kiss_random_generator.sv
test/kiss_random_generator_checker.sv
test/kiss_random_generator_tb.sv
